// File: design/gwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwe_pkg: shared types and constants of the wave equation grid stepper
// Field widths, request and register codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package gwe_pkg;

   localparam int COORD_W    = 3;
   localparam int HEIGHT_W   = 16;
   localparam int DT_W       = 16;
   localparam int DIR_W      = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int MASK_W     = 4;
   localparam int VDIV_W     = 18;
   localparam int FSTEP_W    = 12;
   localparam int BANK_W     = 2;
   localparam int ADDR_W     = BANK_W + 2 * COORD_W;
   localparam int CELL_W     = 2 * COORD_W;
   localparam int SUM_W      = 19;
   localparam int PROD_W     = 36;
   localparam int MAG_W      = 34;
   localparam int ACC_W      = 38;
   localparam int DCNT_W     = 6;
   localparam int STEP_W     = 3;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HEIGHT = 2'd2;

   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VDIV  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FSTEP = 2'd3;

   // Read sequence of one cell.
   localparam logic [STEP_W-1:0] RD_SELF  = 3'd0;
   localparam logic [STEP_W-1:0] RD_PREV  = 3'd1;
   localparam logic [STEP_W-1:0] RD_LEFT  = 3'd2;
   localparam logic [STEP_W-1:0] RD_RIGHT = 3'd3;
   localparam logic [STEP_W-1:0] RD_UP    = 3'd4;
   localparam logic [STEP_W-1:0] RD_DOWN  = 3'd5;
   localparam logic [STEP_W-1:0] RD_END   = 3'd6;

   localparam logic [HEIGHT_W-1:0] MIDLINE = 16'h7FFF;
   localparam logic [HEIGHT_W-1:0] HMAX    = 16'hFFFF;
   localparam logic [DCNT_W-1:0]   DIV_LAST = 6'(MAG_W - 1);

   typedef struct packed {
      logic               load_req;
      logic               clr_wr;
      logic               wr_cur;
      logic               wr_prev;
      logic               wr_force;
      logic               rd_issue;
      logic [STEP_W-1:0]  rd_item;
      logic               take;
      logic [STEP_W-1:0]  take_item;
      logic               mul;
      logic               div_load;
      logic               div_step;
      logic               fin;
      logic               emit;
   } gwe_cmd_type;

   typedef struct packed {
      logic req_tick;
      logic req_dir_ok;
      logic req_hgt_ok;
      logic clr_done;
      logic rsp_free;
      logic last_cell;
   } gwe_status_type;

endpackage

// File: design/gwe_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwe_req_if: request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface gwe_req_if;
   import gwe_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [COORD_W-1:0]  cell_x;
   logic [COORD_W-1:0]  cell_y;
   logic [DIR_W-1:0]    force_dir;
   logic [HEIGHT_W-1:0] new_height;
   logic [DT_W-1:0]     delta_t2;

   modport source (output valid, req_type, cell_x, cell_y, force_dir, new_height,
                   delta_t2, input ready);
   modport sink (input valid, req_type, cell_x, cell_y, force_dir, new_height,
                 delta_t2, output ready);
endinterface

// File: design/gwe_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwe_rsp_if: result channel
// Valid/ready channel carrying one cell result beat.
// ----------------------------------------------------------------------------
interface gwe_rsp_if;
   import gwe_pkg::*;
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  out_x;
   logic [COORD_W-1:0]  out_y;
   logic [HEIGHT_W-1:0] height;
   logic                last;

   modport source (output valid, out_x, out_y, height, last, input ready);
   modport sink (input valid, out_x, out_y, height, last, output ready);
endinterface

// File: design/gwe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwe_ctrl: sequencer of the grid stepper
// Clears the stores after reset, executes writes, and walks each cell of a
// tick through read, multiply, divide, sum and emit.
// ----------------------------------------------------------------------------
module gwe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gwe_pkg::gwe_status_type st,
   output gwe_pkg::gwe_cmd_type    cmd
);
   import gwe_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_WR_CUR   = 4'd2;
   localparam logic [3:0] ST_WR_PREV  = 4'd3;
   localparam logic [3:0] ST_WR_FORCE = 4'd4;
   localparam logic [3:0] ST_READ     = 4'd5;
   localparam logic [3:0] ST_MUL      = 4'd6;
   localparam logic [3:0] ST_DLOAD    = 4'd7;
   localparam logic [3:0] ST_DIV      = 4'd8;
   localparam logic [3:0] ST_SUM      = 4'd9;
   localparam logic [3:0] ST_EMIT     = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      dcnt_in   = dcnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               step_in = RD_SELF;
               if (st.req_tick) begin
                  state_in = ST_READ;
               end else if (st.req_dir_ok) begin
                  state_in = ST_WR_FORCE;
               end else if (st.req_hgt_ok) begin
                  state_in = ST_WR_CUR;
               end
            end
         end
         ST_WR_CUR: begin
            cmd.wr_cur = 1'b1;
            state_in = ST_WR_PREV;
         end
         ST_WR_PREV: begin
            cmd.wr_prev = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WR_FORCE: begin
            cmd.wr_force = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            // Read data arrives in the cycle after its address.
            cmd.rd_issue  = (step_ff != RD_END);
            cmd.rd_item   = step_ff;
            cmd.take      = (step_ff != RD_SELF);
            cmd.take_item = step_ff - 3'd1;
            step_in = step_ff + 3'd1;
            if (step_ff == RD_END) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            dcnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.fin = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               step_in = RD_SELF;
               state_in = st.last_cell ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= RD_SELF;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken outside idle");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.rsp_free)
      else $error("result register overwritten");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && st.last_cell) |=> (state_ff == ST_IDLE))
      else $error("tick did not end after last cell");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff <= DIV_LAST))
      else $error("divider ran past its length");

endmodule

// File: design/gwe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwe_dp: datapath of the grid stepper
// Plane memory with three rotating banks, forcing memory, configuration
// registers, neighbour accumulator, multiplier, serial divider and output
// register.
// ----------------------------------------------------------------------------
module gwe_dp #(
   parameter int GRID_WIDTH  = 8,
   parameter int GRID_HEIGHT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gwe_pkg::gwe_cmd_type             cmd,
   output gwe_pkg::gwe_status_type          st,
   input  logic                             csr_we,
   input  logic [gwe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gwe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [gwe_pkg::KIND_W-1:0]       req_type,
   input  logic [gwe_pkg::COORD_W-1:0]      req_cell_x,
   input  logic [gwe_pkg::COORD_W-1:0]      req_cell_y,
   input  logic [gwe_pkg::DIR_W-1:0]        req_force_dir,
   input  logic [gwe_pkg::HEIGHT_W-1:0]     req_new_height,
   input  logic [gwe_pkg::DT_W-1:0]         req_delta_t2,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gwe_pkg::COORD_W-1:0]      rsp_out_x,
   output logic [gwe_pkg::COORD_W-1:0]      rsp_out_y,
   output logic [gwe_pkg::HEIGHT_W-1:0]     rsp_height,
   output logic                             rsp_last
);
   import gwe_pkg::*;

   localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_HEIGHT - 1);
   localparam logic [COORD_W:0]   X_LIM  = (COORD_W + 1)'(GRID_WIDTH);
   localparam logic [COORD_W:0]   Y_LIM  = (COORD_W + 1)'(GRID_HEIGHT);
   localparam int                 DEPTH  = 2 ** ADDR_W;
   localparam int                 FDEPTH = 2 ** CELL_W;

   // Configuration.
   logic [MASK_W-1:0]  mask_ff;
   logic               fixed_ff;
   logic [VDIV_W-1:0]  vdiv_ff;
   logic [FSTEP_W-1:0] fstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= 4'hF;
         fixed_ff <= 1'b0;
         vdiv_ff  <= 18'h10000;
         fstep_ff <= 12'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASK:  mask_ff  <= csr_wdata[MASK_W-1:0];
            CSR_FIXED: fixed_ff <= csr_wdata[0];
            CSR_VDIV:  vdiv_ff  <= csr_wdata[VDIV_W-1:0];
            CSR_FSTEP: fstep_ff <= csr_wdata[FSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Request latch and cell walk.
   logic [COORD_W-1:0]  x_ff, y_ff;
   logic [DIR_W-1:0]    dir_ff;
   logic [HEIGHT_W-1:0] hv_ff;
   logic [DT_W-1:0]     dt_ff;
   logic [BANK_W-1:0]   cur_bank_ff, prev_bank_ff, next_bank_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic                last_cell;
   logic                in_grid;

   assign last_cell = (x_ff == X_LAST) && (y_ff == Y_LAST);
   assign in_grid   = ({1'b0, req_cell_x} < X_LIM) && ({1'b0, req_cell_y} < Y_LIM);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff   <= (req_type == KIND_TICK) ? '0 : req_cell_x;
         y_ff   <= (req_type == KIND_TICK) ? '0 : req_cell_y;
         dir_ff <= req_force_dir;
         hv_ff  <= req_new_height;
         dt_ff  <= req_delta_t2;
      end else if (cmd.emit) begin
         if (y_ff == Y_LAST) begin
            y_ff <= '0;
            x_ff <= x_ff + 3'd1;
         end else begin
            y_ff <= y_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bank_ff  <= 2'd0;
         prev_bank_ff <= 2'd1;
         next_bank_ff <= 2'd2;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.emit && last_cell) begin
            prev_bank_ff <= cur_bank_ff;
            cur_bank_ff  <= next_bank_ff;
            next_bank_ff <= prev_bank_ff;
         end
         if (cmd.clr_wr) begin
            clr_addr_ff <= clr_addr_ff + 8'd1;
         end
      end
   end

   // Memories.
   logic [HEIGHT_W-1:0] plane_mem [DEPTH];
   logic [DIR_W-1:0]    force_mem [FDEPTH];
   logic                pwe, fwe;
   logic [ADDR_W-1:0]   pwaddr, praddr;
   logic [CELL_W-1:0]   fwaddr;
   logic [HEIGHT_W-1:0] pwdata, prd_ff;
   logic [DIR_W-1:0]    fwdata, frd_ff;
   logic [HEIGHT_W-1:0] h_ff;

   always_comb begin
      pwe    = 1'b0;
      pwaddr = {cur_bank_ff, x_ff, y_ff};
      pwdata = hv_ff;
      fwe    = 1'b0;
      fwaddr = {x_ff, y_ff};
      fwdata = dir_ff;
      if (cmd.clr_wr) begin
         pwe    = 1'b1;
         pwaddr = clr_addr_ff;
         pwdata = '0;
         fwe    = 1'b1;
         fwaddr = clr_addr_ff[CELL_W-1:0];
         fwdata = '0;
      end else if (cmd.wr_cur) begin
         pwe = 1'b1;
      end else if (cmd.wr_prev) begin
         pwe    = 1'b1;
         pwaddr = {prev_bank_ff, x_ff, y_ff};
      end else if (cmd.emit) begin
         pwe    = 1'b1;
         pwaddr = {next_bank_ff, x_ff, y_ff};
         pwdata = h_ff;
      end else if (cmd.wr_force) begin
         fwe = 1'b1;
      end
   end

   always_comb begin
      case (cmd.rd_item)
         RD_PREV:  praddr = {prev_bank_ff, x_ff, y_ff};
         RD_LEFT:  praddr = {cur_bank_ff, x_ff - 3'd1, y_ff};
         RD_RIGHT: praddr = {cur_bank_ff, x_ff + 3'd1, y_ff};
         RD_UP:    praddr = {cur_bank_ff, x_ff, y_ff - 3'd1};
         RD_DOWN:  praddr = {cur_bank_ff, x_ff, y_ff + 3'd1};
         default:  praddr = {cur_bank_ff, x_ff, y_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         plane_mem[pwaddr] <= pwdata;
      end
      if (cmd.rd_issue) begin
         prd_ff <= plane_mem[praddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fwe) begin
         force_mem[fwaddr] <= fwdata;
      end
      frd_ff <= force_mem[{x_ff, y_ff}];
   end

   // Neighbour accumulation.
   logic [HEIGHT_W-1:0]    cur_ff, prev_ff, nval;
   logic [DIR_W-1:0]       fdir_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                   n_en, n_edge;

   always_comb begin
      case (cmd.take_item)
         RD_LEFT: begin
            n_en = mask_ff[0];
            n_edge = (x_ff == '0);
         end
         RD_RIGHT: begin
            n_en = mask_ff[1];
            n_edge = (x_ff == X_LAST);
         end
         RD_UP: begin
            n_en = mask_ff[2];
            n_edge = (y_ff == '0);
         end
         RD_DOWN: begin
            n_en = mask_ff[3];
            n_edge = (y_ff == Y_LAST);
         end
         default: begin
            n_en = 1'b0;
            n_edge = 1'b0;
         end
      endcase
      nval = n_edge ? (fixed_ff ? MIDLINE : cur_ff) : prd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         if (cmd.take_item == RD_SELF) begin
            cur_ff  <= prd_ff;
            fdir_ff <= frd_ff;
            sum_ff  <= '0;
         end else if (cmd.take_item == RD_PREV) begin
            prev_ff <= prd_ff;
         end else if (n_en) begin
            sum_ff <= sum_ff + signed'({3'b000, nval}) - signed'({3'b000, cur_ff});
         end
      end
   end

   // Multiply, then restoring division of the magnitude.
   logic signed [PROD_W-1:0] prod_ff;
   logic                     neg_ff;
   logic [MAG_W-1:0]         quo_ff, mag;
   logic [VDIV_W-1:0]        rem_ff, dvs;
   logic [VDIV_W:0]          trial;

   assign mag   = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : prod_ff[MAG_W-1:0];
   assign dvs   = (vdiv_ff == '0) ? 18'd1 : vdiv_ff;
   assign trial = {rem_ff, quo_ff[MAG_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= sum_ff * signed'({1'b0, dt_ff});
      end
      if (cmd.div_load) begin
         neg_ff <= prod_ff[PROD_W-1];
         quo_ff <= mag;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, dvs}) begin
            rem_ff <= VDIV_W'(trial - {1'b0, dvs});
            quo_ff <= {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[VDIV_W-1:0];
            quo_ff <= {quo_ff[MAG_W-2:0], 1'b0};
         end
      end
   end

   // Final sum and clamp.
   logic signed [ACC_W-1:0] q_s, f_s, acc;

   always_comb begin
      q_s = signed'({4'b0000, quo_ff});
      if (neg_ff) begin
         q_s = -q_s;
      end
      if (fdir_ff == DIR_UP) begin
         f_s = signed'(ACC_W'(fstep_ff));
      end else if (fdir_ff == DIR_DOWN) begin
         f_s = -signed'(ACC_W'(fstep_ff));
      end else begin
         f_s = '0;
      end
      acc = signed'(ACC_W'({cur_ff, 1'b0})) - signed'(ACC_W'(prev_ff)) + q_s + f_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         if (acc < 0) begin
            h_ff <= '0;
         end else if (acc > signed'(ACC_W'(HMAX))) begin
            h_ff <= HMAX;
         end else begin
            h_ff <= acc[HEIGHT_W-1:0];
         end
      end
   end

   // Output register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_x  <= x_ff;
         rsp_out_y  <= y_ff;
         rsp_height <= h_ff;
         rsp_last   <= last_cell;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign st.req_tick   = (req_type == KIND_TICK);
   assign st.req_dir_ok = (req_type == KIND_DIR) && in_grid;
   assign st.req_hgt_ok = (req_type == KIND_HEIGHT) && in_grid;
   assign st.clr_done   = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign st.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign st.last_cell  = last_cell;

endmodule

// File: design/grid_wave_equation_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_wave_equation_step: 2-D wave equation stepper over a small grid
//
//   Port       Dir  Beat contents
//   req_chan   in   req_type, cell_x, cell_y, force_dir, new_height, delta_t2
//   rsp_chan   out  out_x, out_y, height, last
//   csr_*      in   csr_we, csr_index, csr_wdata (write only)
//
// Height writes update the current, then the previous plane; direction writes
// update the forcing memory. A tick emits one beat per cell after six reads
// through the single plane memory port, one multiply and a one-bit-per-cycle
// divider over 34 quotient bits. After reset a clearing pass zeroes the stores;
// no request is taken meanwhile. A stalled result beat holds the cell walk.
// ----------------------------------------------------------------------------
module grid_wave_equation_step #(
   parameter int GRID_WIDTH  = 8,
   parameter int GRID_HEIGHT = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   gwe_req_if.sink                        req_chan,
   gwe_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [gwe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gwe_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gwe_pkg::*;

   gwe_cmd_type    cmd;
   gwe_status_type st;
   logic           req_ready;

   assign req_chan.ready = req_ready;

   gwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   gwe_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_chan.req_type),
      .req_cell_x     (req_chan.cell_x),
      .req_cell_y     (req_chan.cell_y),
      .req_force_dir  (req_chan.force_dir),
      .req_new_height (req_chan.new_height),
      .req_delta_t2   (req_chan.delta_t2),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_out_x      (rsp_chan.out_x),
      .rsp_out_y      (rsp_chan.out_y),
      .rsp_height     (rsp_chan.height),
      .rsp_last       (rsp_chan.last)
   );

endmodule
